/* rtl/core/shor_pkg.sv */
// ----------------------------------------------------------------------------
// shor_pkg
// Shared widths, opcodes and the divider status type for the sorted hash overlap block.
// ----------------------------------------------------------------------------
package shor_pkg;

   localparam int HASH_W         = 64;
   localparam int OP_W           = 2;
   localparam int COUNT_W        = 11;
   localparam int RATIO_W        = 17;
   localparam int LIST_DEPTH_DEF = 1024;

   localparam logic [OP_W-1:0] OP_LOAD_A  = 2'd0;
   localparam logic [OP_W-1:0] OP_LOAD_B  = 2'd1;
   localparam logic [OP_W-1:0] OP_COMPARE = 2'd2;

   // Divider status seen by the control logic.
   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

/* rtl/core/shor_list_mem.sv */
// ----------------------------------------------------------------------------
// shor_list_mem
// One hash list: a simple dual-port memory, one write and one registered read.
// ----------------------------------------------------------------------------
module shor_list_mem #(
   parameter int DEPTH = shor_pkg::LIST_DEPTH_DEF,
   parameter int AW    = 10
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [shor_pkg::HASH_W-1:0] wr_data,
   input  logic [AW-1:0]               rd_addr,
   output logic [shor_pkg::HASH_W-1:0] rd_data
);
   import shor_pkg::*;

   logic [HASH_W-1:0] mem [DEPTH];
   logic [HASH_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/shor_divider.sv */
// ----------------------------------------------------------------------------
// shor_divider
// Radix-2 restoring divider: floor(count * 65536 / total), one quotient bit
// per cycle.
// ----------------------------------------------------------------------------
module shor_divider #(
   parameter int LW = 11
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [LW-1:0]                numer,
   input  logic [LW-1:0]                denom,
   output shor_pkg::div_status_type     status,
   output logic [shor_pkg::RATIO_W-1:0] quotient
);
   import shor_pkg::*;

   localparam int CW = $clog2(RATIO_W + 1);

   logic [LW-1:0]      rem_ff, rem_in;
   logic [LW-1:0]      denom_ff, denom_in;
   logic               nbit_ff, nbit_in;
   logic [RATIO_W-1:0] q_ff, q_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [LW:0]        trial;
   logic [LW:0]        diff;
   logic               fits;

   // Quotient is below 2^17 since numer <= denom, so the numerator bits above
   // bit 16 of numer*2^16 form a starting remainder already below denom.
   assign trial = {rem_ff, nbit_ff};
   assign diff  = trial - {1'b0, denom_ff};
   assign fits  = (trial >= {1'b0, denom_ff});

   always_comb begin
      rem_in   = rem_ff;
      denom_in = denom_ff;
      nbit_in  = nbit_ff;
      q_in     = q_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = numer >> 1;
         nbit_in  = numer[0];
         denom_in = denom;
         q_in     = '0;
         cnt_in   = CW'(RATIO_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         rem_in  = fits ? diff[LW-1:0] : trial[LW-1:0];
         q_in    = {q_ff[RATIO_W-2:0], fits};
         nbit_in = 1'b0;
         cnt_in  = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff   <= rem_in;
      denom_ff <= denom_in;
      nbit_ff  <= nbit_in;
      q_ff     <= q_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = q_ff;

endmodule

/* rtl/core/sorted_hash_overlap_ratio.sv */
// ----------------------------------------------------------------------------
// sorted_hash_overlap_ratio
// Loads two ascending lists of signed 64-bit hashes and reports how many
// hashes they share, as a count and as a Q1.16 fraction of the longer list.
// ----------------------------------------------------------------------------
// Each request beat carries an op: load A, load B or compare. A load writes
// the hash at the tail of its list memory; a load to a full list is dropped
// and remembered in the overflowed flag. A load is taken even while a
// response beat is still waiting. A compare walks both list memories with a
// two-pointer merge, one element pair per cycle, because the registered read
// port of each memory is addressed from the next pointer value. A restoring
// divider then forms floor(match * 65536 / total) for the response beat.
// While a response beat waits, a new compare is held off. When both lists
// are empty, the ratio is zero and empty_error is set. Op code 3 is taken
// and ignored. The list memories need no clearing: only entries below the
// current lengths are read. The threshold register may be written at any
// time through the csr channel, which is always ready.
// ----------------------------------------------------------------------------
module sorted_hash_overlap_ratio #(
   parameter int LIST_DEPTH = shor_pkg::LIST_DEPTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [shor_pkg::OP_W-1:0]           req_op,
   input  logic signed [shor_pkg::HASH_W-1:0]  req_hash_value,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [shor_pkg::COUNT_W-1:0]        rsp_match_count,
   output logic [shor_pkg::COUNT_W-1:0]        rsp_total_count,
   output logic [shor_pkg::RATIO_W-1:0]        rsp_ratio_q16,
   output logic                                rsp_above_threshold,
   output logic                                rsp_empty_error,
   output logic                                rsp_overflowed,
   // configuration channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [shor_pkg::RATIO_W-1:0]        csr_threshold_q16
);
   import shor_pkg::*;

   // Length counters hold 0..LIST_DEPTH; addresses only 0..LIST_DEPTH-1.
   localparam int LW = $clog2(LIST_DEPTH + 1);
   localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MERGE,
      ST_DIVIDE
   } state_type;

   state_type          state_ff, state_in;
   logic [LW-1:0]      len_a_ff, len_a_in;
   logic [LW-1:0]      len_b_ff, len_b_in;
   logic [LW-1:0]      ptr_a_ff, ptr_a_in;
   logic [LW-1:0]      ptr_b_ff, ptr_b_in;
   logic [LW-1:0]      hits_ff, hits_in;
   logic [LW-1:0]      total_ff, total_in;
   logic               ovf_ff, ovf_in;
   logic [RATIO_W-1:0] thresh_ff, thresh_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_match_ff, rsp_match_in;
   logic [COUNT_W-1:0] rsp_total_ff, rsp_total_in;
   logic [RATIO_W-1:0] rsp_ratio_ff, rsp_ratio_in;
   logic               rsp_above_ff, rsp_above_in;
   logic               rsp_empty_ff, rsp_empty_in;
   logic               rsp_ovf_ff, rsp_ovf_in;

   logic               req_fire;
   logic               a_room;
   logic               b_room;
   logic               wr_a;
   logic               wr_b;
   logic [HASH_W-1:0]  rd_a;
   logic [HASH_W-1:0]  rd_b;
   logic               div_start;
   div_status_type     div_stat;
   logic [RATIO_W-1:0] div_q;
   logic               empty;
   logic [LW+COUNT_W-1:0] hits_wide;
   logic [LW+COUNT_W-1:0] total_wide;

   // Hold off any beat while a compare runs; hold off a compare while the
   // previous response still waits.
   assign req_stall = (state_ff != ST_IDLE) ||
                      (rsp_valid_ff && (req_op == OP_COMPARE));
   assign req_fire  = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign a_room = (len_a_ff < LW'(LIST_DEPTH));
   assign b_room = (len_b_ff < LW'(LIST_DEPTH));
   assign wr_a   = req_fire && (req_op == OP_LOAD_A) && a_room;
   assign wr_b   = req_fire && (req_op == OP_LOAD_B) && b_room;

   shor_list_mem #(
      .DEPTH (LIST_DEPTH),
      .AW    (AW)
   ) u_list_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (len_a_ff[AW-1:0]),
      .wr_data (req_hash_value),
      .rd_addr (ptr_a_in[AW-1:0]),
      .rd_data (rd_a)
   );

   shor_list_mem #(
      .DEPTH (LIST_DEPTH),
      .AW    (AW)
   ) u_list_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (len_b_ff[AW-1:0]),
      .wr_data (req_hash_value),
      .rd_addr (ptr_b_in[AW-1:0]),
      .rd_data (rd_b)
   );

   shor_divider #(
      .LW (LW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (hits_ff),
      .denom    (total_in),
      .status   (div_stat),
      .quotient (div_q)
   );

   assign empty      = (total_ff == '0);
   // Mask counts to the 11-bit response fields for any list depth.
   assign hits_wide  = {{COUNT_W{1'b0}}, hits_ff};
   assign total_wide = {{COUNT_W{1'b0}}, total_ff};

   always_comb begin
      state_in     = state_ff;
      len_a_in     = len_a_ff;
      len_b_in     = len_b_ff;
      ptr_a_in     = ptr_a_ff;
      ptr_b_in     = ptr_b_ff;
      hits_in      = hits_ff;
      total_in     = (len_a_ff > len_b_ff) ? len_a_ff : len_b_ff;
      ovf_in       = ovf_ff;
      thresh_in    = thresh_ff;
      div_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_match_in = rsp_match_ff;
      rsp_total_in = rsp_total_ff;
      rsp_ratio_in = rsp_ratio_ff;
      rsp_above_in = rsp_above_ff;
      rsp_empty_in = rsp_empty_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      if (csr_valid) begin
         thresh_in = csr_threshold_q16;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_op)
                  OP_LOAD_A: begin
                     if (a_room) len_a_in = len_a_ff + LW'(1);
                     else        ovf_in   = 1'b1;
                  end
                  OP_LOAD_B: begin
                     if (b_room) len_b_in = len_b_ff + LW'(1);
                     else        ovf_in   = 1'b1;
                  end
                  OP_COMPARE: begin
                     // Rewind both pointers; the reads of entry 0 land next cycle.
                     ptr_a_in = '0;
                     ptr_b_in = '0;
                     hits_in  = '0;
                     state_in = ST_MERGE;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_MERGE: begin
            // rd_a and rd_b hold the entries at the current pointers.
            if ((ptr_a_ff < len_a_ff) && (ptr_b_ff < len_b_ff)) begin
               if ($signed(rd_a) < $signed(rd_b)) begin
                  ptr_a_in = ptr_a_ff + LW'(1);
               end else if ($signed(rd_a) > $signed(rd_b)) begin
                  ptr_b_in = ptr_b_ff + LW'(1);
               end else begin
                  hits_in  = hits_ff + LW'(1);
                  ptr_a_in = ptr_a_ff + LW'(1);
                  ptr_b_in = ptr_b_ff + LW'(1);
               end
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               rsp_valid_in = 1'b1;
               rsp_match_in = hits_wide[COUNT_W-1:0];
               rsp_total_in = total_wide[COUNT_W-1:0];
               rsp_ratio_in = empty ? '0 : div_q;
               rsp_above_in = !empty && (div_q > thresh_ff);
               rsp_empty_in = empty;
               rsp_ovf_in   = ovf_ff;
               // Clear both lists and the overflow flag for the next round.
               len_a_in     = '0;
               len_b_in     = '0;
               ovf_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         len_a_ff     <= '0;
         len_b_ff     <= '0;
         ptr_a_ff     <= '0;
         ptr_b_ff     <= '0;
         ovf_ff       <= 1'b0;
         thresh_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_a_ff     <= len_a_in;
         len_b_ff     <= len_b_in;
         ptr_a_ff     <= ptr_a_in;
         ptr_b_ff     <= ptr_b_in;
         ovf_ff       <= ovf_in;
         thresh_ff    <= thresh_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hits_ff      <= hits_in;
      total_ff     <= total_in;
      rsp_match_ff <= rsp_match_in;
      rsp_total_ff <= rsp_total_in;
      rsp_ratio_ff <= rsp_ratio_in;
      rsp_above_ff <= rsp_above_in;
      rsp_empty_ff <= rsp_empty_in;
      rsp_ovf_ff   <= rsp_ovf_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_match_count     = rsp_match_ff;
   assign rsp_total_count     = rsp_total_ff;
   assign rsp_ratio_q16       = rsp_ratio_ff;
   assign rsp_above_threshold = rsp_above_ff;
   assign rsp_empty_error     = rsp_empty_ff;
   assign rsp_overflowed      = rsp_ovf_ff;

`ifndef ASSERT_OFF
   // A compare is never taken over a response beat that still waits.
   a_no_compare_over_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_op == OP_COMPARE)) |-> !rsp_valid_ff)
      else $error("compare accepted while response pending");

   // The divider is running or finishing whenever control waits on it.
   a_div_alive: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (div_stat.busy || div_stat.done))
      else $error("divide state without divider activity");

   // An empty-list response carries a zero ratio and no threshold hit.
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_empty_ff) |->
         ((rsp_ratio_ff == '0) && !rsp_above_ff && (rsp_total_ff == '0)))
      else $error("empty response with nonzero fields");
`endif

endmodule
